// ===== design/ilm_pkg.sv =====
// ----------------------------------------------------------------------------
// ilm_pkg
// Shared types and codes for the index-linked list manager: command and
// status codes, list selectors, payload words and the link RAM request.
// ----------------------------------------------------------------------------
package ilm_pkg;

  // Width of a head or link value, which also holds the end marker.
  localparam int LINK_W = 9;
  // Widest link RAM address that any legal slot count needs.
  localparam int ADDR_MAX_W = 8;
  // Slot count and list head value loaded at reset.
  localparam logic [LINK_W-1:0] SLOT_CAP = 9'd256;

  // Command codes.
  localparam logic [1:0] CMD_INIT = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PUSH = 2'd2;
  localparam logic [1:0] CMD_XFER = 2'd3;

  // List selectors. The fourth code names a list that is always empty.
  localparam logic [1:0] LIST_FREE = 2'd0;
  localparam logic [1:0] LIST_WAIT = 2'd1;
  localparam logic [1:0] LIST_PROC = 2'd2;
  localparam logic [1:0] LIST_NONE = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [1:0] ST_PUSH_RANGE = 2'd2;
  localparam logic [1:0] ST_XFER_EMPTY = 2'd3;

  // Input command word.
  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] list_select;
    logic [1:0] target_list;
    logic [7:0] slot_index;
  } ilm_in_t;

  // Result word.
  typedef struct packed {
    logic [7:0] popped_slot;
    logic [1:0] status;
  } ilm_out_t;

  // Request from the controller to the link RAM.
  typedef struct packed {
    logic                  rd_en;
    logic [ADDR_MAX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [ADDR_MAX_W-1:0] wr_addr;
    logic [LINK_W-1:0]     wr_data;
  } ilm_ram_req_t;

endpackage

// ===== design/index_linked_list_manager_top.sv =====
// ----------------------------------------------------------------------------
// index_linked_list_manager_top
// Pool of message slots on free, waiting and processing lists, linked
// through a next-index RAM.
// ----------------------------------------------------------------------------
// Push, transfer and every failed command: result in the cycle after start.
// Pop: busy while S_POP takes the link RAM read data; result registered from S_POP.
// Init: busy in S_INIT, one link write per cycle; result registered with the last write.
// Push and transfer may be issued every cycle; results cannot be stalled.
// Reset: lists empty (head 256), slot count 256, link RAM undefined until written.
module index_linked_list_manager_top
  import ilm_pkg::*;
#(
  parameter int MAX_SLOTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ilm_in_t           in_word,
  output logic              out_valid,
  output ilm_out_t          out_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LINK_W-1:0] cfg_data
);

  // Only slots below 256 can ever be addressed.
  localparam int DEPTH  = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
  localparam int ADDR_W = $clog2(DEPTH);

  ilm_ram_req_t      ram_req;
  logic [LINK_W-1:0] ram_rd_data;

  // Command sequencer and list heads.
  ilm_ctrl #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_word    (out_word),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  // Next-index memory.
  ilm_link_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_link_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

endmodule

// ===== design/ilm_link_ram.sv =====
// ----------------------------------------------------------------------------
// ilm_link_ram
// Next-index memory: one write port and one read port with registered read
// data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module ilm_link_ram
  import ilm_pkg::*;
#(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  ilm_ram_req_t      req,
  output logic [LINK_W-1:0] rd_data
);

  logic [LINK_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[ADDR_W-1:0]] <= req.wr_data;
    end
  end

  // Read port with registered read data, held when no read is enabled.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[ADDR_W-1:0]];
    end
  end

endmodule

// ===== design/ilm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilm_ctrl
// Command sequencer: holds the three list heads and the slot count, drives
// the link RAM for pop, push and the init sweep, and registers each result.
// ----------------------------------------------------------------------------
module ilm_ctrl
  import ilm_pkg::*;
#(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ilm_in_t           in_word,
  output logic              out_valid,
  output ilm_out_t          out_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LINK_W-1:0] cfg_data,
  output ilm_ram_req_t      ram_req,
  input  logic [LINK_W-1:0] ram_rd_data
);

  localparam logic [LINK_W-1:0] DEPTH_CNT = LINK_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_INIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [LINK_W-1:0]   count_r, count_nxt;
  logic [LINK_W-1:0]   free_r, free_nxt;
  logic [LINK_W-1:0]   wait_r, wait_nxt;
  logic [LINK_W-1:0]   proc_r, proc_nxt;
  logic [ADDR_W-1:0]   ctr_r, ctr_nxt;
  logic [ADDR_W-1:0]   pop_addr_r, pop_addr_nxt;
  logic [1:0]          pop_sel_r, pop_sel_nxt;
  logic                out_valid_r, out_valid_nxt;
  ilm_out_t            out_r, out_nxt;

  logic                accept;
  logic [LINK_W-1:0]   n_eff;
  logic [LINK_W-1:0]   src_head;
  logic [LINK_W-1:0]   push_link;

  // Effective slot count, saturated at the memory depth.
  assign n_eff = (count_r > DEPTH_CNT) ? DEPTH_CNT : count_r;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // Head of the selected source list; the fourth selector reads as empty.
  always_comb begin
    case (in_word.list_select)
      LIST_FREE: src_head = free_r;
      LIST_WAIT: src_head = wait_r;
      LIST_PROC: src_head = proc_r;
      default:   src_head = n_eff;
    endcase
  end

  // A push onto a list whose head is exactly the end marker links the marker.
  assign push_link = (src_head == n_eff) ? n_eff : src_head;

  // Next-state logic for the sequencer, heads and result register.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    free_nxt      = free_r;
    wait_nxt      = wait_r;
    proc_nxt      = proc_r;
    ctr_nxt       = ctr_r;
    pop_addr_nxt  = pop_addr_r;
    pop_sel_nxt   = pop_sel_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_req       = '0;

    if (cfg_valid) begin
      count_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.popped_slot = 8'd0;
          out_nxt.status      = ST_OK;
          case (in_word.cmd)
            CMD_INIT: begin
              free_nxt = '0;
              wait_nxt = n_eff;
              proc_nxt = n_eff;
              ctr_nxt  = '0;
              if (n_eff == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_INIT;
              end
            end
            CMD_POP: begin
              if (in_word.list_select == LIST_NONE || src_head >= n_eff) begin
                out_nxt.status = ST_POP_EMPTY;
                out_valid_nxt  = 1'b1;
              end else begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = ADDR_MAX_W'(src_head[ADDR_W-1:0]);
                pop_addr_nxt    = src_head[ADDR_W-1:0];
                pop_sel_nxt     = in_word.list_select;
                state_nxt       = S_POP;
              end
            end
            CMD_PUSH: begin
              out_valid_nxt = 1'b1;
              if (LINK_W'(in_word.slot_index) >= n_eff) begin
                out_nxt.status = ST_PUSH_RANGE;
              end else if (in_word.list_select != LIST_NONE) begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = ADDR_MAX_W'(in_word.slot_index[ADDR_W-1:0]);
                ram_req.wr_data = push_link;
                case (in_word.list_select)
                  LIST_FREE: free_nxt = LINK_W'(in_word.slot_index);
                  LIST_WAIT: wait_nxt = LINK_W'(in_word.slot_index);
                  default:   proc_nxt = LINK_W'(in_word.slot_index);
                endcase
              end
            end
            default: begin
              // Transfer: target takes the source head, then the source empties.
              out_valid_nxt = 1'b1;
              if (in_word.list_select == LIST_NONE || src_head >= n_eff) begin
                out_nxt.status = ST_XFER_EMPTY;
              end else begin
                case (in_word.target_list)
                  LIST_FREE: free_nxt = src_head;
                  LIST_WAIT: wait_nxt = src_head;
                  LIST_PROC: proc_nxt = src_head;
                  default:   ;
                endcase
                case (in_word.list_select)
                  LIST_FREE: free_nxt = n_eff;
                  LIST_WAIT: wait_nxt = n_eff;
                  default:   proc_nxt = n_eff;
                endcase
              end
            end
          endcase
        end
      end
      S_POP: begin
        // Link data of the detached slot is back: advance the head, end the slot.
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = ADDR_MAX_W'(pop_addr_r);
        ram_req.wr_data = n_eff;
        case (pop_sel_r)
          LIST_FREE: free_nxt = ram_rd_data;
          LIST_WAIT: wait_nxt = ram_rd_data;
          default:   proc_nxt = ram_rd_data;
        endcase
        out_nxt.popped_slot = 8'(pop_addr_r);
        out_nxt.status      = ST_OK;
        out_valid_nxt       = 1'b1;
        state_nxt           = S_IDLE;
      end
      S_INIT: begin
        // Thread one slot per cycle onto its successor.
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = ADDR_MAX_W'(ctr_r);
        ram_req.wr_data = LINK_W'(ctr_r) + LINK_W'(1);
        if (LINK_W'(ctr_r) == n_eff - LINK_W'(1)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ctr_nxt = ctr_r + ADDR_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, heads and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= SLOT_CAP;
      free_r      <= SLOT_CAP;
      wait_r      <= SLOT_CAP;
      proc_r      <= SLOT_CAP;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      free_r      <= free_nxt;
      wait_r      <= wait_nxt;
      proc_r      <= proc_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pop_addr_r <= pop_addr_nxt;
    pop_sel_r  <= pop_sel_nxt;
    out_r      <= out_nxt;
  end

  // A push is answered in the very next cycle.
  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.cmd == CMD_PUSH) |=> out_valid_r)
    else $error("push result missing");

  // The pop read-back cycle always finishes with a result and returns to idle.
  a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (out_valid_r && state_r == S_IDLE))
    else $error("pop did not complete");

  // Only a successful pop reports a nonzero slot.
  a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_OK) |-> (out_r.popped_slot == 8'd0))
    else $error("slot reported on failed command");

  // No result is shown while the init sweep is still writing links.
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT && $past(state_r) == S_INIT) |-> !out_valid_r)
    else $error("result during init sweep");

endmodule
